// ===== rtl/core/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the stream find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // longest replacement, and so the most results one request can cause
  localparam int REPL_MAX    = 8;
  localparam int ITEM_W      = $clog2(REPL_MAX);
  // one result left over plus a full burst
  localparam int QUEUE_DEPTH = REPL_MAX + 1;
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int LEN_W     = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES      = 2'd0,
    REG_PATTERN_LENGTH     = 2'd1,
    REG_REPLACEMENT_BYTES  = 2'd2,
    REG_REPLACEMENT_LENGTH = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       run_last;
    logic       end_mark;
  } result_t;

  typedef struct packed {
    logic en;
    logic load;
    logic shift;
  } win_ctrl_t;

  typedef struct packed {
    logic load;
    logic shift;
  } q_ctrl_t;

endpackage

// ===== rtl/core/sfr_win_cell.sv =====
// ----------------------------------------------------------------------------
// sfr_win_cell
// One byte of the pending window: takes the incoming byte, compares with its
// pattern byte and hands its byte to the older neighbor on a shift.
// ----------------------------------------------------------------------------
module sfr_win_cell (
  input  logic              clk,
  input  sfr_pkg::win_ctrl_t ctrl,
  input  logic [7:0]        data_in,
  input  logic [7:0]        younger,
  input  logic [7:0]        pat_byte,
  output logic [7:0]        cur,
  output logic              eq
);
  import sfr_pkg::*;

  logic [7:0] held;

  // byte as seen after the incoming byte is appended
  assign cur = ctrl.load ? data_in : held;
  assign eq  = (cur == pat_byte);

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      held <= ctrl.shift ? younger : cur;
    end
  end

endmodule

// ===== rtl/core/sfr_q_cell.sv =====
// ----------------------------------------------------------------------------
// sfr_q_cell
// One slot of the result queue: loads a new result or takes its neighbor's
// on a shift toward the head.
// ----------------------------------------------------------------------------
module sfr_q_cell (
  input  logic              clk,
  input  sfr_pkg::q_ctrl_t  ctrl,
  input  sfr_pkg::result_t  new_item,
  input  sfr_pkg::result_t  behind,
  output sfr_pkg::result_t  item
);
  import sfr_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      item <= new_item;
    end else if (ctrl.shift) begin
      item <= behind;
    end
  end

endmodule

// ===== rtl/core/stream_find_replace.sv =====
// ----------------------------------------------------------------------------
// stream_find_replace
// Replaces every leftmost, non-overlapping occurrence of a pattern in a byte
// stream with a replacement, using a row of window cells and a result queue.
// ----------------------------------------------------------------------------
// channel  dir  tdata                                tuser          tlast
// s_*      in   [7:0] data_byte                      carries_byte   end_of_string
// m_*      out  [7:0] out_byte, [8] last_in_run      out_has_byte   end_of_output
// cfg_*    in   cfg_index selects register, cfg_data holds the value
//
// A request is taken whenever the result queue holds at most one entry, so a
// request that causes at most one result goes through at one per cycle while
// the receiver takes a result every cycle. A request that causes n results
// loads all n into the queue at once; they leave one per cycle while the
// receiver is ready. Results appear at the earliest in the cycle after their request.
// Reset clears the window fill, the queue count and the registers, but sets the pattern length to one.
// ----------------------------------------------------------------------------
module stream_find_replace #(
  parameter int MAX_PATTERN = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] data_byte
  input  logic                          s_tuser,   // carries_byte
  input  logic                          s_tlast,   // end_of_string
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [15:0]                   m_tdata,   // [7:0] out_byte, [8] last_in_run
  output logic                          m_tuser,   // out_has_byte
  output logic                          m_tlast,   // end_of_output
  input  logic                          cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfr_pkg::CFG_W-1:0]     cfg_data
);
  import sfr_pkg::*;

  localparam int FW = $clog2(MAX_PATTERN + 1);

  // configuration
  logic [8*MAX_PATTERN-1:0] pattern_bytes;
  logic [LEN_W-1:0]         pattern_length;
  logic [8*REPL_MAX-1:0]    replacement_bytes;
  logic [LEN_W-1:0]         replacement_length;

  logic [FW-1:0]      fill, fill_next, fill_app;
  logic [COUNT_W-1:0] count, count_next, base;
  logic [LEN_W-1:0]   plen, rlen, n_raw, n_res, cnt;
  logic               accept, pop, full, match, use_repl, bare, eos, has;

  logic [7:0]      wp  [MAX_PATTERN];
  logic [7:0]      nb  [MAX_PATTERN];
  logic            eq  [MAX_PATTERN];
  win_ctrl_t       wctl[MAX_PATTERN];
  result_t         items [REPL_MAX];
  result_t         qitem [QUEUE_DEPTH];
  result_t         qnew  [QUEUE_DEPTH];
  result_t         qbehind [QUEUE_DEPTH];
  q_ctrl_t         qctl  [QUEUE_DEPTH];

  assign has    = s_tuser;
  assign eos    = s_tlast;
  assign s_tready = (count <= COUNT_W'(1));
  assign accept = s_tvalid && s_tready;
  assign m_tvalid = (count != '0);
  assign pop    = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= LEN_W'(1);
      replacement_bytes  <= '0;
      replacement_length <= '0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_PATTERN_BYTES:      pattern_bytes      <= cfg_data[8*MAX_PATTERN-1:0];
        REG_PATTERN_LENGTH:     pattern_length     <= cfg_data[LEN_W-1:0];
        REG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg_data[8*REPL_MAX-1:0];
        REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp lengths to their usable ranges
  always_comb begin
    plen = pattern_length;
    if (plen == '0) plen = LEN_W'(1);
    if (plen > LEN_W'(MAX_PATTERN)) plen = LEN_W'(MAX_PATTERN);
    rlen = replacement_length;
    if (rlen > LEN_W'(REPL_MAX)) rlen = LEN_W'(REPL_MAX);
  end

  assign fill_app = fill + FW'(has && (fill < FW'(MAX_PATTERN)));
  assign full     = (LEN_W'(fill_app) >= plen);

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((LEN_W'(i) < plen) && !eq[i]) match = 1'b0;
    end
  end

  assign use_repl = full && match;

  // window cells
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_win
    if (i == MAX_PATTERN - 1) begin : g_end
      assign nb[i] = 8'h00;
    end else begin : g_mid
      assign nb[i] = wp[i+1];
    end
    assign wctl[i] = '{en:    accept,
                       load:  has && (fill == FW'(i)),
                       shift: full && !match};
    sfr_win_cell u_cell (
      .clk      (clk),
      .ctrl     (wctl[i]),
      .data_in  (s_tdata),
      .younger  (nb[i]),
      .pat_byte (pattern_bytes[8*i +: 8]),
      .cur      (wp[i]),
      .eq       (eq[i])
    );
  end

  always_comb begin
    if (eos || use_repl) fill_next = '0;
    else if (full)       fill_next = fill_app - FW'(1);
    else                 fill_next = fill_app;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cfg_we && (reg_index_t'(cfg_index) == REG_PATTERN_LENGTH)) begin
      fill <= '0;
    end else if (accept) begin
      fill <= fill_next;
    end
  end

  // results of this request: replacement bytes, window bytes from the head, or a bare end marker
  assign cnt   = eos ? LEN_W'(fill_app) : LEN_W'(full);
  assign n_raw = use_repl ? rlen : cnt;
  assign bare  = eos && (n_raw == '0);
  assign n_res = bare ? LEN_W'(1) : n_raw;

  for (genvar j = 0; j < REPL_MAX; j++) begin : g_item
    logic [7:0] wbyte;
    if (j < MAX_PATTERN) begin : g_w
      assign wbyte = wp[j];
    end else begin : g_z
      assign wbyte = 8'h00;
    end
    assign items[j].data     = bare ? 8'h00 : (use_repl ? replacement_bytes[8*j +: 8] : wbyte);
    assign items[j].has_byte = !bare;
    assign items[j].run_last = (LEN_W'(j) == n_res - LEN_W'(1));
    assign items[j].end_mark = eos && (LEN_W'(j) == n_res - LEN_W'(1));
  end

  // result queue
  assign base = count - COUNT_W'(pop);

  always_comb begin
    logic [COUNT_W-1:0] idx;
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      idx = COUNT_W'(k) - base;
      qnew[k] = items[idx[ITEM_W-1:0]];
      qctl[k].load  = accept && (COUNT_W'(k) >= base) && (idx < COUNT_W'(n_res));
      qctl[k].shift = pop;
    end
  end

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_q
    if (k == QUEUE_DEPTH - 1) begin : g_end
      assign qbehind[k] = qitem[k];
    end else begin : g_mid
      assign qbehind[k] = qitem[k+1];
    end
    sfr_q_cell u_qcell (
      .clk      (clk),
      .ctrl     (qctl[k]),
      .new_item (qnew[k]),
      .behind   (qbehind[k]),
      .item     (qitem[k])
    );
  end

  assign count_next = base + (accept ? COUNT_W'(n_res) : COUNT_W'(0));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign m_tdata = {7'b0, qitem[0].run_last, qitem[0].data};
  assign m_tuser = qitem[0].has_byte;
  assign m_tlast = qitem[0].end_mark;

endmodule

// ===== test/tb_stream_find_replace.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stream_find_replace
// Streams byte strings through the find-and-replace block under a series of
// pattern and replacement settings. Random stalls and gaps sit on both
// streams. A scoreboard holds its own copy of the match window and compares
// every result with the bytes it expects.
// ----------------------------------------------------------------------------
module tb_stream_find_replace;
  import sfr_pkg::*;

  localparam int TOTAL_ITEMS = 300;   // the last setting's strings can carry it past this, to at most 624
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE      = 16;
  localparam int LONG_HOLD   = 80;

  class rewrite_board;
    result_t     expected_q[$];
    logic [63:0] pat_word;
    logic [63:0] rep_word;
    logic [3:0]  pat_len;
    logic [3:0]  rep_len;
    logic [7:0]  window [8];
    int unsigned fill;
    int unsigned errors, requests, results, hits;

    function new();
      pat_word = '0;
      pat_len  = 4'd1;
      rep_word = '0;
      rep_len  = 4'd0;
      fill     = 0;
      errors   = 0;
      requests = 0;
      results  = 0;
      hits     = 0;
    endfunction

    // length the block actually compares, after clamping
    function int unsigned pattern_span();
      if (pat_len == 4'd0) return 1;
      if (pat_len > 4'd8) return 8;
      return pat_len;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function result_t item_of(logic [7:0] b, logic has);
      return '{data: b, has_byte: has, run_last: 1'b0, end_mark: 1'b0};
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task write_reg(reg_index_t idx, logic [63:0] value);
      case (idx)
        REG_PATTERN_BYTES: begin
          pat_word = value;
        end
        REG_PATTERN_LENGTH: begin
          pat_len = value[3:0];
          fill    = 0;
        end
        REG_REPLACEMENT_BYTES: begin
          rep_word = value;
        end
        REG_REPLACEMENT_LENGTH: begin
          rep_len = value[3:0];
        end
        default: begin
        end
      endcase
    endtask

    task note_request(logic [7:0] b, logic has, logic eos);
      result_t     burst[$];
      int unsigned span, rlen, i;
      bit          hit;
      span = pattern_span();
      rlen = (rep_len > 4'd8) ? 8 : rep_len;
      requests++;
      if (has && fill < 8) begin
        window[fill] = b;
        fill++;
      end
      if (fill >= span) begin
        hit = 1'b1;
        for (i = 0; i < span; i++) begin
          if (window[i] != pat_word[8*i +: 8]) hit = 1'b0;
        end
        if (hit) begin
          hits++;
          for (i = 0; i < rlen; i++) burst.push_back(item_of(rep_word[8*i +: 8], 1'b1));
          fill = 0;
        end else begin
          // no match: oldest byte leaves, the rest move up
          burst.push_back(item_of(window[0], 1'b1));
          for (i = 0; i < 7; i++) window[i] = window[i+1];
          fill--;
        end
      end
      if (eos) begin
        for (i = 0; i < fill; i++) burst.push_back(item_of(window[i], 1'b1));
        fill = 0;
        if (burst.size() == 0) burst.push_back(item_of(8'h00, 1'b0));
        burst[burst.size()-1].end_mark = 1'b1;
      end
      if (burst.size() > 0) burst[burst.size()-1].run_last = 1'b1;
      foreach (burst[k]) expected_q.push_back(burst[k]);
    endtask

    task check_result(result_t got);
      result_t want;
      results++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d (byte %02h has %b) with nothing expected",
                         results, got.data, got.has_byte));
      end else begin
        want = expected_q.pop_front();
        if (got.data != want.data || got.has_byte != want.has_byte ||
            got.run_last != want.run_last || got.end_mark != want.end_mark)
          report($sformatf("result %0d got/want byte %02h/%02h has %b/%b last %b/%b end %b/%b",
                           results, got.data, want.data, got.has_byte, want.has_byte,
                           got.run_last, want.run_last, got.end_mark, want.end_mark));
      end
    endtask
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata   = '0;
  logic                 s_tuser   = 1'b0;
  logic                 s_tlast   = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [15:0]          m_tdata;
  logic                 m_tuser;
  logic                 m_tlast;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  rewrite_board board;
  int  sent        = 0;
  int  settings    = 0;
  int  rx_hold     = 0;
  int  stall_count = 0;
  bit  calm        = 1'b0;

  stream_find_replace dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               stall_count, board.pending());
      $display("stream_find_replace verification failed");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int      gap;
    result_t got;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (rx_hold > 0) begin
        gap     = rx_hold;
        rx_hold = 0;
      end else begin
        gap = calm ? 0 : $urandom_range(0, 7);
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      got = '{data: m_tdata[7:0], has_byte: m_tuser, run_last: m_tdata[8], end_mark: m_tlast};
      board.check_result(got);
      @(negedge clk);
    end
  end

  task send_request(logic [7:0] b, logic has, logic eos);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= has;
    s_tlast  <= eos;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_request(b, has, eos);
    sent++;
    @(negedge clk);
  endtask

  // keeps the write enable high across back-to-back writes
  task put_reg(reg_index_t idx, logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    board.write_reg(idx, value);
    @(negedge clk);
  endtask

  task load_rewrite(logic [63:0] pat, logic [3:0] plen, logic [63:0] rep, logic [3:0] rlen);
    put_reg(REG_PATTERN_BYTES, pat);
    put_reg(REG_PATTERN_LENGTH, 64'(plen));
    put_reg(REG_REPLACEMENT_BYTES, rep);
    put_reg(REG_REPLACEMENT_LENGTH, 64'(rlen));
    cfg_we <= 1'b0;
    settings++;
  endtask

  // wait for every expected result, then let the block settle
  task drain();
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // one string: whole pattern copies half of the time, the rest cut short, noise or idle
  task send_text(int unsigned chunks);
    int unsigned span, cut, c, k;
    span = board.pattern_span();
    for (c = 0; c < chunks; c++) begin
      case ($urandom_range(0, 7))
        0, 1, 2, 3: begin
          for (k = 0; k < span; k++) send_request(board.pat_word[8*k +: 8], 1'b1, 1'b0);
        end
        4: begin
          cut = $urandom_range(1, span);
          for (k = 0; k < cut; k++) send_request(board.pat_word[8*k +: 8], 1'b1, 1'b0);
        end
        5: begin
          send_request(8'($urandom), 1'b1, 1'b0);
        end
        6: begin
          k = $urandom_range(0, span - 1);
          send_request(board.pat_word[8*k +: 8], 1'b1, 1'b0);
        end
        default: begin
          // idle request, data is ignored
          send_request(8'($urandom), 1'b0, 1'b0);
        end
      endcase
    end
    k = $urandom_range(0, span - 1);
    case ($urandom_range(0, 3))
      0: send_request(8'($urandom), 1'b0, 1'b1);
      1: send_request(8'($urandom), 1'b1, 1'b1);
      default: send_request(board.pat_word[8*k +: 8], 1'b1, 1'b1);
    endcase
  endtask

  initial begin
    logic [63:0] pat, rep;
    logic [3:0]  plen, rlen;
    logic [7:0]  a, b;
    int          phase, k;
    board = new();
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: single zero byte pattern, matches deleted
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hff, 1'b1, 1'b1);
    drain();

    // "ab" -> "XYZ": plain hit, overlapping prefix, idle, flush, bare end
    load_rewrite(64'h6261, 4'd2, 64'h5a5958, 4'd3);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h55, 1'b0, 1'b1);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b1);
    send_request(8'h00, 1'b0, 1'b1);
    drain();

    // longest pattern and longest replacement
    load_rewrite(64'hffff_ffff_ffff_ffff, 4'd8, 64'h0123_4567_89ab_cdef, 4'd8);
    repeat (8) send_request(8'hff, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    drain();

    // pattern length zero acts as one, replacement length clamps to eight
    load_rewrite(64'h0, 4'd0, 64'hfedc_ba98_7654_3210, 4'd15);
    send_request(8'h00, 1'b1, 1'b1);
    drain();

    phase = 0;
    while (sent < TOTAL_ITEMS) begin
      plen = 4'($urandom_range(1, 8));
      if ($urandom_range(0, 9) == 0) plen = $urandom_range(0, 1) ? 4'd15 : 4'd0;
      rlen = 4'($urandom_range(0, 8));
      if ($urandom_range(0, 9) == 0) rlen = 4'($urandom_range(9, 15));
      pat = {$urandom, $urandom};
      rep = {$urandom, $urandom};
      // two-letter patterns give overlapping partial matches
      if ($urandom_range(0, 2) == 0) begin
        a = 8'($urandom);
        b = 8'($urandom);
        for (k = 0; k < 8; k++) pat[8*k +: 8] = $urandom_range(0, 1) ? a : b;
      end
      if (phase == 0) begin
        plen = 4'd1;
        rlen = 4'd8;
      end
      load_rewrite(pat, plen, rep, rlen);
      if (phase == 0) begin
        // full-rate input against a held-off receiver fills the queue
        calm    = 1'b1;
        rx_hold = LONG_HOLD;
        send_text(24);
      end else begin
        calm = ($urandom_range(0, 4) == 0);
        repeat ($urandom_range(2, 5)) send_text($urandom_range(1, 8));
      end
      calm = 1'b0;
      drain();
      phase++;
    end

    $display("covered %0d requests, %0d results, %0d pattern hits",
             board.requests, board.results, board.hits);
    $display("across %0d register settings, clamped lengths and deletions included",
             settings);
    if (board.errors == 0) begin
      $display("stream_find_replace verification clean");
    end else begin
      $display("stream_find_replace verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sfr_pkg.sv
rtl/core/sfr_win_cell.sv
rtl/core/sfr_q_cell.sv
rtl/core/stream_find_replace.sv
test/tb_stream_find_replace.sv
